@@ rtl/bcs_pkg.sv @@
// shared types, codes and reset values of the blink code sequencer
`timescale 1ns / 1ps

package bcs_pkg;

    // default widths of durations and code counts
    localparam int TIME_BITS_DEF = 16;
    localparam int CODE_BITS_DEF = 8;

    // item kinds carried in func
    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_REQ  = 2'd1;
    localparam logic [1:0] FUNC_STOP = 2'd2;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SHORT_HALF  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LONG_HALF   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SLOW_SOURCE = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_GAP  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ROUND_GAP   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ROUND_COUNT = 3'd5;

    // register reset values
    localparam logic [15:0] SHORT_HALF_RST  = 16'd250;
    localparam logic [15:0] LONG_HALF_RST   = 16'd350;
    localparam logic [3:0]  SLOW_SOURCE_RST = 4'd8;
    localparam logic [15:0] SOURCE_GAP_RST  = 16'd500;
    localparam logic [15:0] ROUND_GAP_RST   = 16'd1500;
    localparam logic [7:0]  ROUND_COUNT_RST = 8'd2;

    // sequencer phases, one-hot
    typedef enum logic [6:0] {
        PH_IDLE     = 7'b0000001,
        PH_SRC_ON   = 7'b0000010,
        PH_SRC_OFF  = 7'b0000100,
        PH_GAP1     = 7'b0001000,
        PH_CODE_ON  = 7'b0010000,
        PH_CODE_OFF = 7'b0100000,
        PH_GAP2     = 7'b1000000
    } phase_t;

    // configuration register file
    typedef struct packed {
        logic [15:0] short_half_ms;
        logic [15:0] long_half_ms;
        logic [3:0]  slow_source;
        logic [15:0] source_gap_ms;
        logic [15:0] round_gap_ms;
        logic [7:0]  round_count;
    } cfg_t;

    // one result item
    typedef struct packed {
        logic led_pin;
        logic busy_res;
        logic request_skipped;
    } result_t;

endpackage

@@ rtl/bcs_if.sv @@
// item channel interfaces of the blink code sequencer
`timescale 1ns / 1ps

interface bcs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [3:0] source_id;
    logic [7:0] code_blinks;
    logic       repeat_forever;

    modport source (
        output valid, func, source_id, code_blinks, repeat_forever,
        input  ready
    );
    modport sink (
        input  valid, func, source_id, code_blinks, repeat_forever,
        output ready
    );
endinterface

interface bcs_out_if;
    logic valid;
    logic ready;
    logic led_pin;
    logic busy_res;
    logic request_skipped;

    modport source (
        output valid, led_pin, busy_res, request_skipped,
        input  ready
    );
    modport sink (
        input  valid, led_pin, busy_res, request_skipped,
        output ready
    );
endinterface

@@ rtl/bcs_core.sv @@
// sequencer state registers and combinational next-state logic
`timescale 1ns / 1ps

module bcs_core #(
    parameter int TIME_BITS = 16,
    parameter int CODE_BITS = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [1:0]      func,
    input  logic [3:0]      source_id,
    input  logic [7:0]      code_blinks,
    input  logic            repeat_forever,
    input  bcs_pkg::cfg_t   cfg,
    output bcs_pkg::result_t result
);
    import bcs_pkg::*;

    localparam logic [32:0] TIME_MAX = (33'd1 << TIME_BITS) - 33'd1;
    localparam logic [16:0] CODE_MAX = (17'd1 << CODE_BITS) - 17'd1;

    typedef struct packed {
        phase_t                phase;
        logic [TIME_BITS-1:0]  time_left;
        logic [CODE_BITS-1:0]  blinks_left;
        logic [7:0]            rounds_left;
        logic [3:0]            held_source_blinks;
        logic [CODE_BITS-1:0]  held_code_blinks;
        logic                  held_forever;
        logic [TIME_BITS-1:0]  held_half_time;
    } seq_state_t;

    seq_state_t           state_reg;
    seq_state_t           state_next;
    logic                 skipped;
    logic [TIME_BITS-1:0] gap1_time;
    logic [TIME_BITS-1:0] gap2_time;

    // clamp a 16-bit duration to the time width
    function automatic logic [TIME_BITS-1:0] sat_time(logic [15:0] v);
        logic [32:0] wide;
        wide = {17'd0, v};
        if (wide > TIME_MAX)
            return TIME_MAX[TIME_BITS-1:0];
        return wide[TIME_BITS-1:0];
    endfunction

    // clamp an 8-bit count to the code width
    function automatic logic [CODE_BITS-1:0] sat_code(logic [7:0] v);
        logic [16:0] wide;
        wide = {9'd0, v};
        if (wide > CODE_MAX)
            return CODE_MAX[CODE_BITS-1:0];
        return wide[CODE_BITS-1:0];
    endfunction

    function automatic seq_state_t start_round(seq_state_t s, logic [TIME_BITS-1:0] g1);
        seq_state_t r;
        r = s;
        r.blinks_left = CODE_BITS'(s.held_source_blinks);
        if (s.held_source_blinks != 4'd0)
        begin
            r.phase     = PH_SRC_ON;
            r.time_left = s.held_half_time;
        end
        else
        begin
            r.phase     = PH_GAP1;
            r.time_left = g1;
        end
        return r;
    endfunction

    function automatic seq_state_t start_code(seq_state_t s, logic [TIME_BITS-1:0] g2);
        seq_state_t r;
        r = s;
        r.blinks_left = s.held_code_blinks;
        if (s.held_code_blinks != '0)
        begin
            r.phase     = PH_CODE_ON;
            r.time_left = s.held_half_time;
        end
        else
        begin
            r.phase     = PH_GAP2;
            r.time_left = g2;
        end
        return r;
    endfunction

    function automatic seq_state_t end_round(seq_state_t s, logic [TIME_BITS-1:0] g1);
        seq_state_t r;
        r = s;
        if (!s.held_forever)
        begin
            if (r.rounds_left != 8'd0)
                r.rounds_left = r.rounds_left - 8'd1;
            if (r.rounds_left == 8'd0)
            begin
                r.phase       = PH_IDLE;
                r.time_left   = '0;
                r.blinks_left = '0;
                return r;
            end
        end
        return start_round(r, g1);
    endfunction

    // advance out of a phase whose time has run out
    function automatic seq_state_t step_phase(seq_state_t s, logic [TIME_BITS-1:0] g1,
                                              logic [TIME_BITS-1:0] g2);
        seq_state_t r;
        r = s;
        case (s.phase)
            PH_SRC_ON:
            begin
                r.phase     = PH_SRC_OFF;
                r.time_left = s.held_half_time;
            end
            PH_SRC_OFF:
            begin
                if (r.blinks_left != '0)
                    r.blinks_left = r.blinks_left - CODE_BITS'(1);
                if (r.blinks_left != '0)
                begin
                    r.phase     = PH_SRC_ON;
                    r.time_left = s.held_half_time;
                end
                else
                begin
                    r.phase     = PH_GAP1;
                    r.time_left = g1;
                end
            end
            PH_GAP1:
                r = start_code(s, g2);
            PH_CODE_ON:
            begin
                r.phase     = PH_CODE_OFF;
                r.time_left = s.held_half_time;
            end
            PH_CODE_OFF:
            begin
                if (r.blinks_left != '0)
                    r.blinks_left = r.blinks_left - CODE_BITS'(1);
                if (r.blinks_left != '0)
                begin
                    r.phase     = PH_CODE_ON;
                    r.time_left = s.held_half_time;
                end
                else
                begin
                    r.phase     = PH_GAP2;
                    r.time_left = g2;
                end
            end
            PH_GAP2:
                r = end_round(s, g1);
            default:
            begin
                r.phase     = PH_IDLE;
                r.time_left = '0;
            end
        endcase
        return r;
    endfunction

    // pass through zero-length pauses, at most one round end
    function automatic seq_state_t settle(seq_state_t s, logic may_end,
                                          logic [TIME_BITS-1:0] g1,
                                          logic [TIME_BITS-1:0] g2);
        seq_state_t r;
        logic       m;
        r = s;
        m = may_end;
        for (int i = 0; i < 4; i++)
        begin
            if (r.phase == PH_GAP1 && r.time_left == '0)
                r = start_code(r, g2);
            else if (r.phase == PH_GAP2 && r.time_left == '0 && m)
            begin
                m = 1'b0;
                r = end_round(r, g1);
            end
        end
        return r;
    endfunction

    // gap times, read live from the registers
    assign gap1_time = sat_time(cfg.source_gap_ms);
    assign gap2_time = sat_time(cfg.round_gap_ms);

    // next state for the item at the input
    always_comb
    begin
        logic        was_gap2;
        logic [15:0] half;
        seq_state_t  tmp;
        state_next = state_reg;
        skipped    = 1'b0;
        was_gap2   = 1'b0;
        half       = 16'd0;
        tmp        = state_reg;
        case (func)
            FUNC_TICK:
            begin
                if (state_reg.phase != PH_IDLE)
                begin
                    if (state_reg.time_left > TIME_BITS'(1))
                        state_next.time_left = state_reg.time_left - TIME_BITS'(1);
                    else
                    begin
                        was_gap2   = (state_reg.phase == PH_GAP2);
                        tmp        = step_phase(state_reg, gap1_time, gap2_time);
                        state_next = settle(tmp, !was_gap2, gap1_time, gap2_time);
                    end
                end
            end
            FUNC_REQ:
            begin
                if (state_reg.phase != PH_IDLE)
                    skipped = 1'b1;
                else
                begin
                    half = (source_id == cfg.slow_source) ? cfg.long_half_ms
                                                          : cfg.short_half_ms;
                    if (half == 16'd0)
                        half = 16'd1;
                    tmp.held_half_time     = sat_time(half);
                    tmp.held_source_blinks = source_id;
                    tmp.held_code_blinks   = sat_code(code_blinks);
                    tmp.held_forever       = repeat_forever;
                    tmp.rounds_left        = (cfg.round_count == 8'd0) ? 8'd1
                                                                       : cfg.round_count;
                    tmp        = start_round(tmp, gap1_time);
                    state_next = settle(tmp, 1'b1, gap1_time, gap2_time);
                end
            end
            FUNC_STOP:
            begin
                state_next.phase       = PH_IDLE;
                state_next.time_left   = '0;
                state_next.blinks_left = '0;
                state_next.rounds_left = 8'd0;
            end
            default:
                state_next = state_reg;
        endcase
    end

    // result fields from the state after the item
    assign result.led_pin = !(state_next.phase == PH_SRC_ON ||
                              state_next.phase == PH_CODE_ON);
    assign result.busy_res        = (state_next.phase != PH_IDLE);
    assign result.request_skipped = skipped;

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase              <= PH_IDLE;
            state_reg.time_left          <= '0;
            state_reg.blinks_left        <= '0;
            state_reg.rounds_left        <= 8'd0;
            state_reg.held_source_blinks <= 4'd0;
            state_reg.held_code_blinks   <= '0;
            state_reg.held_forever       <= 1'b0;
            state_reg.held_half_time     <= '0;
        end
        else if (accept)
            state_reg <= state_next;
    end

endmodule

@@ rtl/blink_code_sequencer.sv @@
// top level of the blink code sequencer: registers, handshake, result register
`timescale 1ns / 1ps

// Drives an active-low status LED with a two-part blink code.
// item_in carries one item per handshake: a 1 ms tick, a blink request
// (source_id, code_blinks, repeat_forever) or a stop, selected by func.
// Each accepted item yields exactly one result item on result_out, holding
// the LED level, the busy flag and whether the request was skipped.
// The result is registered and is valid the cycle after its item is accepted.
// Throughput: one item per cycle unless result_out stalls; the whole update of
// phase and counters is one pass of combinational logic into the state registers.
// A single result register sits between the channels: item_in stays ready
// while the held result is being taken, and stalls only while result_out
// holds a result that the receiver does not take.
// Configuration goes through cfg_we / cfg_index / cfg_wdata, one register
// per cycle, and is meant to be written while the block is idle.
// Reset (rst_n, asynchronous, active low) sets the registers to their
// defaults, the sequencer to idle and empties the result register.

module blink_code_sequencer #(
    parameter int TIME_BITS = bcs_pkg::TIME_BITS_DEF,
    parameter int CODE_BITS = bcs_pkg::CODE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    bcs_in_if.sink                             item_in,
    bcs_out_if.source                          result_out,
    input  logic                               cfg_we,
    input  logic [bcs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [bcs_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
    import bcs_pkg::*;

    cfg_t    cfg_reg;
    result_t result_next;
    result_t result_reg;
    logic    out_valid_reg;
    logic    accept;

    // input handshake
    assign item_in.ready = !out_valid_reg || result_out.ready;
    assign accept        = item_in.valid && item_in.ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_half_ms <= SHORT_HALF_RST;
            cfg_reg.long_half_ms  <= LONG_HALF_RST;
            cfg_reg.slow_source   <= SLOW_SOURCE_RST;
            cfg_reg.source_gap_ms <= SOURCE_GAP_RST;
            cfg_reg.round_gap_ms  <= ROUND_GAP_RST;
            cfg_reg.round_count   <= ROUND_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SHORT_HALF:  cfg_reg.short_half_ms <= cfg_wdata;
                REG_LONG_HALF:   cfg_reg.long_half_ms  <= cfg_wdata;
                REG_SLOW_SOURCE: cfg_reg.slow_source   <= cfg_wdata[3:0];
                REG_SOURCE_GAP:  cfg_reg.source_gap_ms <= cfg_wdata;
                REG_ROUND_GAP:   cfg_reg.round_gap_ms  <= cfg_wdata;
                REG_ROUND_COUNT: cfg_reg.round_count   <= cfg_wdata[7:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    // sequencer
    bcs_core #(
        .TIME_BITS (TIME_BITS),
        .CODE_BITS (CODE_BITS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .func           (item_in.func),
        .source_id      (item_in.source_id),
        .code_blinks    (item_in.code_blinks),
        .repeat_forever (item_in.repeat_forever),
        .cfg            (cfg_reg),
        .result         (result_next)
    );

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (result_out.ready)
            out_valid_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign result_out.valid           = out_valid_reg;
    assign result_out.led_pin         = result_reg.led_pin;
    assign result_out.busy_res        = result_reg.busy_res;
    assign result_out.request_skipped = result_reg.request_skipped;

endmodule
